### src/lrg_pkg.sv
// Package for the latency-driven resolution governor.
// Field widths, register indexes, reset values, fixed ratios, size clamps and the clamp function.
// No dependencies.
package lrg_pkg;

  // Field widths
  localparam int unsigned LAT_W   = 20;
  localparam int unsigned BUDG_W  = 20;
  localparam int unsigned FULL_W  = 14;
  localparam int unsigned FRAME_W = 12;
  localparam int unsigned DIV_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned NUM_DIV = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_BUDGET    = 3'd1,
    CFG_FULL_WID  = 3'd2,
    CFG_FULL_HGT  = 3'd3,
    CFG_START_DIV = 3'd4
  } cfg_idx_t;

  // Register reset values
  localparam logic              ENABLE_RST = 1'b1;
  localparam logic [BUDG_W-1:0] BUDGET_RST = 20'd33333;
  localparam logic [FULL_W-1:0] FULL_WID_RST = 14'd1920;
  localparam logic [FULL_W-1:0] FULL_HGT_RST = 14'd1080;
  localparam logic [DIV_W-1:0]  DIV_RST = 2'd0;

  // Average thresholds as tenths: 1.4 and 0.6 times the budget
  localparam int unsigned AVG_DEN = 10;
  localparam int unsigned HI_NUM  = 14;
  localparam int unsigned LO_NUM  = 6;

  // Output size clamps
  localparam logic [FULL_W-1:0] MIN_FRAME_WID = 14'd64;
  localparam logic [FULL_W-1:0] MAX_FRAME_WID = 14'd3840;
  localparam logic [FULL_W-1:0] MIN_FRAME_HGT = 14'd36;
  localparam logic [FULL_W-1:0] MAX_FRAME_HGT = 14'd2160;

  // Divisor tiers
  localparam logic [DIV_W-1:0] DIV_ONE = 2'd0;
  localparam logic [DIV_W-1:0] DIV_TWO = 2'd1;

  // Clamp a shifted size into [lo, hi] and narrow it to the frame width
  function automatic logic [FRAME_W-1:0] clamp_size(
    input logic [FULL_W-1:0] v,
    input logic [FULL_W-1:0] lo,
    input logic [FULL_W-1:0] hi
  );
    logic [FULL_W-1:0] c;
    if (v < lo) begin
      c = lo;
    end else if (v > hi) begin
      c = hi;
    end else begin
      c = v;
    end
    return c[FRAME_W-1:0];
  endfunction

endpackage

### src/lrg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the latency sample ring. No dependencies.
module lrg_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/latency_driven_resolution_governor_top.sv
// Latency-driven resolution governor, top level.
// Depends on lrg_pkg and lrg_ram (sample ring storage).
//
//   Channel  | Ports                                          | Direction
//   ---------+------------------------------------------------+----------
//   in       | in_valid, in_ready, in_latency_us              | sink
//   out      | out_valid, out_ready, out_divisor_log2,        | source
//            | out_frame_width, out_frame_height,             |
//            | out_skip_next, out_tier_changed                |
//   cfg      | cfg_wr_en, cfg_index, cfg_wr_data              | sink
//
// One item per cycle sustained while the output is not stalled. Stage one reads
// the ring slot that the item replaces; stage two, when enabled, updates sum, fill,
// streak, cooldown and divisor and writes the slot, and always loads the output.
// The next item reads slot index+1 while the previous item writes its slot.
// Reset (rst_n low, synchronous) clears all control state; the ring needs no
// clearing since a slot is only read after it has been written.
// A full output register with out_ready low holds the item in stage two and
// drops in_ready.
module latency_driven_resolution_governor_top #(
  parameter int unsigned WINDOW      = 16,
  parameter int unsigned PROMOTE_RUN = 32,
  parameter int unsigned COOLDOWN    = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lrg_pkg::LAT_W-1:0]      in_latency_us,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lrg_pkg::DIV_W-1:0]      out_divisor_log2,
  output logic [lrg_pkg::FRAME_W-1:0]    out_frame_width,
  output logic [lrg_pkg::FRAME_W-1:0]    out_frame_height,
  output logic                           out_skip_next,
  output logic                           out_tier_changed,
  input  logic                           cfg_wr_en,
  input  logic [lrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrg_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import lrg_pkg::*;

  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = LAT_W + $clog2(WINDOW);
  localparam int unsigned LIM_W  = SUM_W + 4;
  localparam int unsigned RUN_W  = $clog2(PROMOTE_RUN + 1);
  localparam int unsigned CD_W   = $clog2(COOLDOWN + 2);

  // Configuration registers
  logic              en_r, en_nxt;
  logic [BUDG_W-1:0] budget_r;
  logic [FULL_W-1:0] full_wid_r;
  logic [FULL_W-1:0] full_hgt_r;

  // Governor state
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [CD_W-1:0]   cd_r, cd_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;

  // Pipeline control and payload
  logic              s1_valid_r, s1_valid_nxt;
  logic [LAT_W-1:0]  s1_lat_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DIV_W-1:0]  out_div_r;
  logic [FRAME_W-1:0] out_wid_r, out_hgt_r;
  logic              out_skip_r, out_chg_r;

  // Limits and size table derived from configuration
  logic [LIM_W-1:0]   hi_lim_r, lo_lim_r;
  logic [FRAME_W-1:0] sz_wid_r [NUM_DIV];
  logic [FRAME_W-1:0] sz_hgt_r [NUM_DIV];

  logic              in_fire, s1_fire;
  logic [IDX_W-1:0]  idx_inc, rd_addr;
  logic [LAT_W-1:0]  old_lat;
  logic              ring_full;
  logic [SUM_W-1:0]  sum_rec;
  logic [LIM_W-1:0]  scaled;
  logic              avg_hi, avg_lo, skip, changed;
  logic [RUN_W-1:0]  run_inc;

  // Handshake
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // Ring slot addressing: a following item reads the next slot
  assign idx_inc = (idx_r == IDX_W'(WINDOW - 1)) ? '0 : idx_r + 1'b1;
  assign rd_addr = s1_valid_r ? idx_inc : idx_r;

  lrg_ram #(
    .WIDTH (LAT_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (s1_fire && en_r),
    .wr_addr (idx_r),
    .wr_data (s1_lat_r),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (old_lat)
  );

  // Sample record and window average
  always_comb begin
    ring_full = (fill_r >= FILL_W'(WINDOW));
    sum_rec   = (ring_full ? sum_r - SUM_W'(old_lat) : sum_r) + SUM_W'(s1_lat_r);
    scaled    = (LIM_W'(sum_rec) << 3) + (LIM_W'(sum_rec) << 1);
    avg_hi    = scaled > hi_lim_r;
    avg_lo    = scaled < lo_lim_r;
    skip      = (budget_r != '0) &&
                ({1'b0, s1_lat_r} > {budget_r, 1'b0});
    run_inc   = run_r + 1'b1;
  end

  // Next state: step commit, then configuration writes
  always_comb begin
    en_nxt   = en_r;
    idx_nxt  = idx_r;
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    run_nxt  = run_r;
    cd_nxt   = cd_r;
    div_nxt  = div_r;
    changed  = 1'b0;

    if (s1_fire && en_r) begin
      idx_nxt  = idx_inc;
      fill_nxt = ring_full ? fill_r : fill_r + 1'b1;
      sum_nxt  = sum_rec;
      // tier decision
      priority if (budget_r == '0) begin
        // no decision
      end else if (cd_r != '0) begin
        cd_nxt = cd_r - 1'b1;
      end else if (fill_nxt < FILL_W'(WINDOW)) begin
        // window still filling
      end else if (avg_hi && div_r <= DIV_TWO) begin
        div_nxt = div_r + 1'b1;
        changed = 1'b1;
      end else if (avg_lo) begin
        run_nxt = run_inc;
        if (run_inc >= RUN_W'(PROMOTE_RUN)) begin
          if (div_r == DIV_ONE) begin
            run_nxt = '0;
          end else begin
            div_nxt = (div_r >= 2'd2) ? DIV_TWO : DIV_ONE;
            changed = 1'b1;
          end
        end
      end else begin
        run_nxt = '0;
      end
      if (changed) begin
        cd_nxt   = CD_W'(COOLDOWN);
        idx_nxt  = '0;
        fill_nxt = '0;
        sum_nxt  = '0;
        run_nxt  = '0;
      end
    end

    // register writes
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENABLE: begin
          en_nxt = cfg_wr_data[0];
          if (cfg_wr_data[0] != en_r) begin
            idx_nxt  = '0;
            fill_nxt = '0;
            sum_nxt  = '0;
            run_nxt  = '0;
            cd_nxt   = '0;
          end
        end
        CFG_START_DIV: div_nxt = cfg_wr_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline valids
  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= ENABLE_RST;
      budget_r    <= BUDGET_RST;
      full_wid_r  <= FULL_WID_RST;
      full_hgt_r  <= FULL_HGT_RST;
      idx_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      run_r       <= '0;
      cd_r        <= '0;
      div_r       <= DIV_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      en_r        <= en_nxt;
      idx_r       <= idx_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      run_r       <= run_nxt;
      cd_r        <= cd_nxt;
      div_r       <= div_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en && cfg_index == CFG_BUDGET) begin
        budget_r <= cfg_wr_data[BUDG_W-1:0];
      end
      if (cfg_wr_en && cfg_index == CFG_FULL_WID) begin
        full_wid_r <= cfg_wr_data[FULL_W-1:0];
      end
      if (cfg_wr_en && cfg_index == CFG_FULL_HGT) begin
        full_hgt_r <= cfg_wr_data[FULL_W-1:0];
      end
    end
  end

  // Payload: stage-one sample, derived limits, size table, output item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_lat_r <= in_latency_us;
    end
    hi_lim_r <= LIM_W'(budget_r) * LIM_W'(HI_NUM * WINDOW);
    lo_lim_r <= LIM_W'(budget_r) * LIM_W'(LO_NUM * WINDOW);
    for (int d = 0; d < NUM_DIV; d++) begin
      sz_wid_r[d] <= clamp_size(full_wid_r >> d, MIN_FRAME_WID, MAX_FRAME_WID);
      sz_hgt_r[d] <= clamp_size(full_hgt_r >> d, MIN_FRAME_HGT, MAX_FRAME_HGT);
    end
    if (s1_fire) begin
      out_div_r <= div_nxt;
      out_wid_r <= sz_wid_r[div_nxt];
      out_hgt_r <= sz_hgt_r[div_nxt];
      out_skip_r <= en_r && skip;
      out_chg_r  <= changed;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_divisor_log2 = out_div_r;
  assign out_frame_width  = out_wid_r;
  assign out_frame_height = out_hgt_r;
  assign out_skip_next    = out_skip_r;
  assign out_tier_changed = out_chg_r;

endmodule

### test/tb.sv
// Testbench for latency_driven_resolution_governor_top: random and directed latency items,
// config sweeps between phases and a scoreboard fed by its own governor model or by
// hand-typed rows. Depends on lrg_pkg and the RTL under src/.
`timescale 1ns / 100ps

module tb;
  import lrg_pkg::*;

  localparam int unsigned WINDOW      = 16;
  localparam int unsigned PROMOTE_RUN = 32;
  localparam int unsigned COOLDOWN    = 16;
  localparam int unsigned IDX_W       = $clog2(WINDOW);
  localparam longint unsigned LAT_MAX = (1 << LAT_W) - 1;
  localparam int unsigned PLAN_ITEMS  = 700;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DIR_N       = 20;
  localparam int unsigned PHASE_N     = 7;
  // Expectation ring: address bits and depth
  localparam int unsigned EXP_AW      = 6;
  localparam int unsigned EXP_DEPTH   = 1 << EXP_AW;
  // Register indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

  typedef struct packed {
    logic [DIV_W-1:0]   div;
    logic [FRAME_W-1:0] wid;
    logic [FRAME_W-1:0] hgt;
    logic               skip;
    logic               changed;
  } frame_res_t;

  typedef struct packed {
    logic [LAT_W-1:0] lat;
    logic             has_lit;
    frame_res_t       lit;
  } dir_row_t;

  typedef struct {
    logic               en;
    logic [BUDG_W-1:0]  budget;
    logic [FULL_W-1:0]  fw;
    logic [FULL_W-1:0]  fh;
    logic [DIV_W-1:0]   sdiv;
    int                 n;
  } phase_t;

  typedef enum {LAT_LOW, LAT_HIGH, LAT_EDGE, LAT_NOISE} lat_mix_t;

  // DUT inputs, all known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [LAT_W-1:0]      in_latency_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DIV_W-1:0]      out_divisor_log2;
  logic [FRAME_W-1:0]    out_frame_width;
  logic [FRAME_W-1:0]    out_frame_height;
  logic                  out_skip_next;
  logic                  out_tier_changed;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  // Hand-typed expectation travels with the item it belongs to
  logic       row_has_lit = 1'b0;
  frame_res_t row_lit = '0;

  // Governor model state
  logic              m_enable = ENABLE_RST;
  logic [BUDG_W-1:0] m_budget = BUDGET_RST;
  logic [FULL_W-1:0] m_fw = FULL_WID_RST;
  logic [FULL_W-1:0] m_fh = FULL_HGT_RST;
  logic [DIV_W-1:0]  m_div = DIV_RST;
  logic [LAT_W-1:0]  m_ring [WINDOW];
  logic [IDX_W-1:0]  m_wr_idx = '0;
  logic [IDX_W:0]    m_fill = '0;
  logic [23:0]       m_sum = '0;
  logic [5:0]        m_streak = '0;
  logic [4:0]        m_cool = '0;

  // Expected results in acceptance order
  frame_res_t exp_ring [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_err = 0;
  int n_tier = 0;
  int n_skip = 0;
  int cycles = 0;

  latency_driven_resolution_governor_top #(
    .WINDOW(WINDOW), .PROMOTE_RUN(PROMOTE_RUN), .COOLDOWN(COOLDOWN)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_latency_us(in_latency_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_divisor_log2(out_divisor_log2), .out_frame_width(out_frame_width),
    .out_frame_height(out_frame_height), .out_skip_next(out_skip_next),
    .out_tier_changed(out_tier_changed),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Results still owed by the DUT
  function automatic int pending();
    return exp_wr - exp_rd;
  endfunction

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results pending", cycles, pending());
      $display("tb: FAIL");
      $finish;
    end
  end

  // Model: drop the averaging window
  function automatic void flush_window();
    m_wr_idx = '0;
    m_fill   = '0;
    m_sum    = '0;
    m_streak = '0;
  endfunction

  function automatic void move_tier(input logic [DIV_W-1:0] d);
    m_div  = d;
    m_cool = 5'(COOLDOWN);
    flush_window();
  endfunction

  // Model: one latency sample in, one frame result out
  function automatic frame_res_t govern_sample(input logic [LAT_W-1:0] lat);
    frame_res_t r;
    logic [FULL_W-1:0] w, h;
    longint unsigned scaled, hi_lim, lo_lim;
    r = '0;
    if (m_enable) begin
      // ring update with running sum
      if (m_fill >= WINDOW) m_sum = m_sum - m_ring[m_wr_idx];
      m_ring[m_wr_idx] = lat;
      m_sum = m_sum + lat;
      m_wr_idx = m_wr_idx + 1'b1;
      if (m_fill < WINDOW) m_fill = m_fill + 1'b1;
      r.skip = (m_budget != 0) && (longint'(lat) > 2 * longint'(m_budget));
      // tier decision
      if (m_budget == 0) begin
      end else if (m_cool != 0) begin
        m_cool = m_cool - 1'b1;
      end else if (m_fill >= WINDOW) begin
        scaled = longint'(m_sum) * AVG_DEN;
        hi_lim = longint'(m_budget) * HI_NUM * WINDOW;
        lo_lim = longint'(m_budget) * LO_NUM * WINDOW;
        if (scaled > hi_lim && m_div <= DIV_TWO) begin
          move_tier(m_div + 1'b1);
          r.changed = 1'b1;
        end else if (scaled < lo_lim) begin
          m_streak = m_streak + 1'b1;
          if (m_streak >= PROMOTE_RUN) begin
            if (m_div > DIV_TWO) begin
              move_tier(DIV_TWO);
              r.changed = 1'b1;
            end else if (m_div == DIV_TWO) begin
              move_tier(DIV_ONE);
              r.changed = 1'b1;
            end else begin
              m_streak = '0;
            end
          end
        end else begin
          m_streak = '0;
        end
      end
    end
    // clamped frame size for the current divisor
    w = m_fw >> m_div;
    h = m_fh >> m_div;
    if (w < MIN_FRAME_WID) w = MIN_FRAME_WID;
    if (w > MAX_FRAME_WID) w = MAX_FRAME_WID;
    if (h < MIN_FRAME_HGT) h = MIN_FRAME_HGT;
    if (h > MAX_FRAME_HGT) h = MAX_FRAME_HGT;
    r.div = m_div;
    r.wid = w[FRAME_W-1:0];
    r.hgt = h[FRAME_W-1:0];
    return r;
  endfunction

  // Random latency shaped around the current budget
  function automatic logic [LAT_W-1:0] pick_latency(input lat_mix_t mix, input int edge_pick);
    longint unsigned b, lo, hi, v;
    int sel;
    b = m_budget;
    v = $urandom_range(LAT_MAX);
    sel = ($urandom_range(3) != 0) ? edge_pick : $urandom_range(5);
    if (b == 0) mix = LAT_NOISE;
    case (mix)
      LAT_LOW: begin
        hi = b * LO_NUM / AVG_DEN;
        v = (hi == 0) ? 0 : $urandom_range(hi - 1);
      end
      LAT_HIGH: begin
        lo = b * HI_NUM / AVG_DEN + 1;
        hi = 3 * b;
        if (lo > LAT_MAX) lo = LAT_MAX;
        if (hi > LAT_MAX) hi = LAT_MAX;
        v = $urandom_range(hi, lo);
      end
      LAT_EDGE: begin
        case (sel)
          0: v = b * HI_NUM / AVG_DEN;
          1: v = b * HI_NUM / AVG_DEN + 1;
          2: v = b * LO_NUM / AVG_DEN;
          3: v = (b * LO_NUM / AVG_DEN == 0) ? 0 : b * LO_NUM / AVG_DEN - 1;
          4: v = 2 * b;
          default: v = 2 * b + 1;
        endcase
      end
      default: begin
        case ($urandom_range(3))
          0: v = 0;
          1: v = LAT_MAX;
          default: ;
        endcase
      end
    endcase
    if (v > LAT_MAX) v = LAT_MAX;
    return v[LAT_W-1:0];
  endfunction

  // Idle mix by position in the run
  task automatic pace_for(input int sent);
    if (sent < PLAN_ITEMS / 3) begin
      tx_idle_pct = 12;
      rx_idle_pct = 74;
    end else if (sent < 2 * PLAN_ITEMS / 3) begin
      tx_idle_pct = 74;
      rx_idle_pct = 12;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // Offer one latency item and hold it until accepted
  task automatic send_item(input logic [LAT_W-1:0] lat, input logic has_lit,
                           input frame_res_t lit);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_latency_us <= lat;
    row_has_lit   <= has_lit;
    row_lit       <= lit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait for every pending result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending() != 0) @(posedge clk);
  endtask

  // Register write, mirrored into the model
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    case (idx)
      CFG_ENABLE: begin
        if (data[0] != m_enable) begin
          flush_window();
          m_cool = '0;
        end
        m_enable = data[0];
      end
      CFG_BUDGET:    m_budget = data[BUDG_W-1:0];
      CFG_FULL_WID:  m_fw = data[FULL_W-1:0];
      CFG_FULL_HGT:  m_fh = data[FULL_W-1:0];
      CFG_START_DIV: m_div = data[DIV_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Input side: predict every accepted item
  always @(posedge clk) begin
    frame_res_t pred;
    if (rst_n && in_valid && in_ready) begin
      pred = govern_sample(in_latency_us);
      exp_ring[exp_wr[EXP_AW-1:0]] = row_has_lit ? row_lit : pred;
      exp_wr++;
      n_items++;
    end
  end

  // Receiver: random stalls plus a single long hold-off
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output side: compare against the oldest expectation
  always @(posedge clk) begin
    frame_res_t want, got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_divisor_log2, out_frame_width, out_frame_height, out_skip_next,
             out_tier_changed};
      n_tier += out_tier_changed;
      n_skip += out_skip_next;
      if (pending() == 0) begin
        n_err++;
        if (n_err <= 10) $display("tb: unexpected result at cycle %0d", cycles);
      end else begin
        want = exp_ring[exp_rd[EXP_AW-1:0]];
        exp_rd++;
        n_checked++;
        if (got !== want) begin
          n_err++;
          if (n_err <= 10)
            $display({"tb: mismatch #%0d div %0d/%0d wid %0d/%0d hgt %0d/%0d",
                      " skip %0b/%0b chg %0b/%0b"},
                     n_checked, want.div, got.div, want.wid, got.wid, want.hgt, got.hgt,
                     want.skip, got.skip, want.changed, got.changed);
        end
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t dir_tab [DIR_N];
    phase_t   phases [PHASE_N];
    lat_mix_t mix;
    int run_left, edge_pick, sent, r;

    // Default registers (budget 33333, 1920x1080, divisor 1): skip above 66666.
    // The window fills on the sixteenth item; from there the model decides.
    dir_tab[0]  = '{20'd0,       1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b0, 1'b0}};
    dir_tab[1]  = '{20'd1,       1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b0, 1'b0}};
    dir_tab[2]  = '{20'd66666,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b0, 1'b0}};
    dir_tab[3]  = '{20'd66667,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b1, 1'b0}};
    dir_tab[4]  = '{20'hFFFFF,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b1, 1'b0}};
    dir_tab[5]  = '{20'h80000,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b1, 1'b0}};
    dir_tab[6]  = '{20'd33333,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b0, 1'b0}};
    dir_tab[7]  = '{20'd46666,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b0, 1'b0}};
    dir_tab[8]  = '{20'd46667,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b0, 1'b0}};
    dir_tab[9]  = '{20'd19999,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b0, 1'b0}};
    dir_tab[10] = '{20'd20000,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b0, 1'b0}};
    dir_tab[11] = '{20'hAAAAA,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b1, 1'b0}};
    dir_tab[12] = '{20'h55555,   1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b1, 1'b0}};
    dir_tab[13] = '{20'd100000,  1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b1, 1'b0}};
    dir_tab[14] = '{20'd2,       1'b1, '{DIV_ONE, 12'd1920, 12'd1080, 1'b0, 1'b0}};
    dir_tab[15] = '{20'hFFFFF,   1'b0, '0};
    dir_tab[16] = '{20'd0,       1'b0, '0};
    dir_tab[17] = '{20'd50000,   1'b0, '0};
    dir_tab[18] = '{20'd10,      1'b0, '0};
    dir_tab[19] = '{20'd80000,   1'b0, '0};

    // enable, budget, width, height, start divisor, items
    phases[0] = '{1'b1, 20'd1000,    14'd1920,  14'd1080,  2'd3, 130};
    phases[1] = '{1'b1, 20'd0,       14'd0,     14'd0,     2'd2, 50};
    phases[2] = '{1'b0, 20'd500,     14'd8192,  14'd8192,  2'd1, 40};
    phases[3] = '{1'b1, 20'hFFFFF,   14'h3FFF,  14'h3FFF,  2'd0, 60};
    phases[4] = '{1'b1, 20'd10,      14'd3840,  14'd2160,  2'd0, 150};
    phases[5] = '{1'b1, 20'd1000000, 14'd640,   14'd360,   2'd1, 60};
    phases[6] = '{1'b1, 20'd250,     14'd7680,  14'd4320,  2'd2, 190};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    sent = 0;
    for (int i = 0; i < DIR_N; i++) begin
      pace_for(sent);
      send_item(dir_tab[i].lat, dir_tab[i].has_lit, dir_tab[i].lit);
      sent++;
    end

    // Random phases, each under its own register settings
    run_left = 0;
    mix = LAT_NOISE;
    edge_pick = 0;
    for (int p = 0; p < PHASE_N; p++) begin
      wait_idle();
      write_reg(CFG_IDX_W'(CFG_SPARE_FIRST + $urandom_range(2)), CFG_DATA_W'($urandom));
      write_reg(CFG_ENABLE,    {19'($urandom), phases[p].en});
      write_reg(CFG_BUDGET,    phases[p].budget);
      write_reg(CFG_FULL_WID,  {6'($urandom), phases[p].fw});
      write_reg(CFG_FULL_HGT,  {6'($urandom), phases[p].fh});
      write_reg(CFG_START_DIV, {18'($urandom), phases[p].sdiv});
      cfg_wr_en <= 1'b0;
      for (int i = 0; i < phases[p].n; i++) begin
        if (run_left == 0) begin
          r = $urandom_range(99);
          mix = (r < 35) ? LAT_LOW : (r < 65) ? LAT_HIGH : (r < 85) ? LAT_EDGE : LAT_NOISE;
          edge_pick = $urandom_range(5);
          run_left = (mix == LAT_LOW) ? $urandom_range(60, 20) : $urandom_range(40, 8);
        end
        run_left--;
        // backpressure long enough to fill the pipeline and stall the input
        if (p == PHASE_N - 1 && i == 40) rx_hold_left = 120;
        // sender pause with nothing in flight
        if (p == 4 && i == 75) wait_idle();
        pace_for(sent);
        send_item(pick_latency(mix, edge_pick), 1'b0, '0);
        sent++;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("tb: %0d latency items over %0d register settings, %0d results checked",
             n_items, PHASE_N + 1, n_checked);
    $display("tb: %0d tier changes, %0d skip flags seen, %0d mismatches, %0d left pending",
             n_tier, n_skip, n_err, pending());
    if (n_err == 0 && pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
